@@ hw/rtl/phs_pkg.sv @@
// shared types, constants and helpers for the packed handle set
// depends on nothing; used by packed_handle_set_swap_remove and phs_checker

package phs_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 512;

	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned TAG_W    = 3;
	localparam int unsigned ENTRY_W  = HANDLE_W + TAG_W;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W   = 9;
	localparam int unsigned COUNT_W  = 10;

	localparam logic [HANDLE_W-1:0] INVALID_HANDLE = '1;

	// slot tags
	localparam logic [TAG_W-1:0] TAG_UNKNOWN    = 3'd0;
	localparam logic [TAG_W-1:0] TAG_CONTROLLER = 3'd1;
	localparam logic [TAG_W-1:0] TAG_WEAPON     = 3'd2;
	localparam logic [TAG_W-1:0] TAG_BOMB       = 3'd3;
	localparam logic [TAG_W-1:0] TAG_PROJECTILE = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_NO_ENTITY = 3'd0;
	localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [HANDLE_W-1:0] handle;
		logic                entity_present;
		logic                is_controller;
		logic                is_weapon;
		logic                is_planted_bomb;
		logic                is_projectile;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  live_count;
	} rsp_t;

	// priority encode of the class flags
	function automatic logic [TAG_W-1:0] class_tag(input req_t r);
		logic [TAG_W-1:0] t;
		if (r.is_controller) begin
			t = TAG_CONTROLLER;
		end else if (r.is_weapon) begin
			t = TAG_WEAPON;
		end else if (r.is_planted_bomb) begin
			t = TAG_BOMB;
		end else if (r.is_projectile) begin
			t = TAG_PROJECTILE;
		end else begin
			t = TAG_UNKNOWN;
		end
		return t;
	endfunction

endpackage

@@ hw/rtl/phs_stream_if.sv @@
// valid/ready channel carrying one word of a given payload type
// depends on nothing; payload types come from phs_pkg

interface phs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/packed_handle_set_swap_remove.sv @@
// search: the linear search reads one slot per cycle from the slot ram; a remove then reads
//   the last slot, moves it into the hole and invalidates its old place (a hit on the last
//   slot is only invalidated)
// handshake: one request at a time; ready returns the cycle after the result is
//   registered, and a stalled result keeps the block from taking a new request
// reset: arst_n clears the live count and control state; the slot ram is not cleared

module packed_handle_set_swap_remove #(
	parameter int unsigned TABLE_DEPTH = phs_pkg::TABLE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	phs_stream_if.sink    req,
	phs_stream_if.source  rsp
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WR_TAG,
		S_WR_NEW,
		S_RD_LAST,
		S_MOVE,
		S_INVAL,
		S_RESP
	} state_t;

	state_t                         state_q;
	phs_pkg::req_t                  req_q;
	logic [phs_pkg::TAG_W-1:0]      tag_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  scan_q;     // next slot to read
	logic                           cmp_vld_s1; // ram data of idx_s1 is on rdata
	logic [AW-1:0]                  idx_s1;
	logic [AW-1:0]                  hit_idx_q;
	logic [phs_pkg::STATUS_W-1:0]   status_q;
	logic [phs_pkg::SLOT_W-1:0]     slot_q;
	logic                           rsp_valid_q;
	phs_pkg::rsp_t                  rsp_q;

	// ram port signals
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [phs_pkg::ENTRY_W-1:0]    mem_wdata;
	logic [AW-1:0]                  mem_raddr;
	logic [phs_pkg::ENTRY_W-1:0]    mem_rdata;

	logic [CW-1:0]                  last_cnt;
	logic [AW-1:0]                  last_idx;
	logic                           match;
	logic                           scan_end;
	logic                           scan_issue;

	// one slot per entry: handle in the upper bits, tag in the low bits
	phs_ram #(
		.WIDTH (phs_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign last_cnt = count_q - CW'(1);
	assign last_idx = last_cnt[AW-1:0];

	// compare stage of the search, in the cycle after the read is issued
	assign match = cmp_vld_s1 &&
		(mem_rdata[phs_pkg::ENTRY_W-1:phs_pkg::TAG_W] == req_q.handle);
	// search is over: last live slot compared, or table empty
	assign scan_end = (count_q == '0) || (cmp_vld_s1 && (CW'(idx_s1) == last_cnt));
	assign scan_issue = (state_q == S_SCAN) && !match && !scan_end && (scan_q < count_q);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = {req_q.handle, tag_q};
		mem_raddr = scan_q[AW-1:0];
		unique case (state_q)
			S_WR_TAG: begin
				mem_we = 1'b1;
			end
			S_WR_NEW: begin
				mem_we    = 1'b1;
				mem_waddr = count_q[AW-1:0];
			end
			S_RD_LAST: begin
				mem_raddr = last_idx;
			end
			S_MOVE: begin
				// last slot fills the hole
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			S_INVAL: begin
				mem_we    = 1'b1;
				mem_waddr = last_idx;
				mem_wdata = {phs_pkg::INVALID_HANDLE, phs_pkg::TAG_UNKNOWN};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
			scan_q      <= '0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			if (scan_issue) begin
				idx_s1 <= scan_q[AW-1:0];
				scan_q <= scan_q + CW'(1);
			end
			// in S_RESP the output register is reloaded below instead
			if (rsp_valid_q && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q  <= req.payload;
						tag_q  <= phs_pkg::class_tag(req.payload);
						scan_q <= '0;
						slot_q <= '0;
						if (req.payload.mode == phs_pkg::MODE_ADD &&
						    !req.payload.entity_present) begin
							status_q <= phs_pkg::ST_NO_ENTITY;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_idx_q <= idx_s1;
						slot_q    <= phs_pkg::SLOT_W'(idx_s1);
						if (req_q.mode == phs_pkg::MODE_ADD) begin
							status_q <= phs_pkg::ST_UPDATED;
							state_q  <= S_WR_TAG;
						end else begin
							status_q <= phs_pkg::ST_REMOVED;
							// hit on the last slot needs no move
							state_q  <= (CW'(idx_s1) == last_cnt) ? S_INVAL : S_RD_LAST;
						end
					end else if (scan_end) begin
						if (req_q.mode == phs_pkg::MODE_REMOVE) begin
							status_q <= phs_pkg::ST_NOT_FOUND;
							state_q  <= S_RESP;
						end else if (tag_q == phs_pkg::TAG_UNKNOWN) begin
							status_q <= phs_pkg::ST_UNKNOWN;
							state_q  <= S_RESP;
						end else if (count_q == CW'(TABLE_DEPTH)) begin
							status_q <= phs_pkg::ST_FULL;
							state_q  <= S_RESP;
						end else begin
							status_q <= phs_pkg::ST_APPENDED;
							slot_q   <= phs_pkg::SLOT_W'(count_q);
							state_q  <= S_WR_NEW;
						end
					end
				end
				S_WR_TAG: begin
					state_q <= S_RESP;
				end
				S_WR_NEW: begin
					count_q <= count_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RD_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					state_q <= S_INVAL;
				end
				S_INVAL: begin
					count_q <= last_cnt;
					state_q <= S_RESP;
				end
				S_RESP: begin
					// output register free or being emptied this cycle
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.status     <= status_q;
						rsp_q.slot       <= slot_q;
						rsp_q.live_count <= phs_pkg::COUNT_W'(count_q);
						state_q          <= S_IDLE;
					end else begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hw/rtl/phs_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module phs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/phs_checker.sv @@
// port-level checks for the packed handle set, bound to the top level
// depends on phs_pkg and packed_handle_set_swap_remove

module phs_checker #(
	parameter int unsigned TABLE_DEPTH = phs_pkg::TABLE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input phs_pkg::rsp_t rsp_payload
);
	logic       req_fire;
	logic       rsp_fire;
	logic [1:0] owed_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// result words owed: accepted requests minus delivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else if (req_fire && !rsp_fire) begin
			owed_q <= owed_q + 2'd1;
		end else if (rsp_fire && !req_fire) begin
			owed_q <= owed_q - 2'd1;
		end
	end

	// at most one finished word may still wait in the output register on accept
	a_one_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> (owed_q <= 2'd1))
		else $error("request accepted while two results are owed");

	// no result word without a request behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> (owed_q != 2'd0))
		else $error("result delivered with no request outstanding");

	// an append lands in the slot just below the new count
	a_append_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_payload.status == phs_pkg::ST_APPENDED) |->
		(phs_pkg::SLOT_W'(rsp_payload.slot + phs_pkg::SLOT_W'(1)) ==
		 rsp_payload.live_count[phs_pkg::SLOT_W-1:0]))
		else $error("appended slot does not match live count");

	// statuses with no slot report slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_payload.status == phs_pkg::ST_NO_ENTITY ||
		               rsp_payload.status == phs_pkg::ST_UNKNOWN ||
		               rsp_payload.status == phs_pkg::ST_FULL ||
		               rsp_payload.status == phs_pkg::ST_NOT_FOUND)) |->
		(rsp_payload.slot == '0))
		else $error("nonzero slot on a status without slot");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
		else $error("result word changed while stalled");
endmodule

bind packed_handle_set_swap_remove phs_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_phs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
